// ===== src/mva_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, command and status codes, and the table write bundle
// for the modular vector ALU. No dependencies.
package mva_pkg;

	localparam int NUM_MODULI = 256;
	localparam int CNT_W      = $clog2(NUM_MODULI + 1);
	localparam int IDX_W      = (NUM_MODULI > 1) ? $clog2(NUM_MODULI) : 1;
	localparam int DATA_W     = 32;
	localparam int MU_W       = 48;

	localparam logic [DATA_W-1:0] MIN_MODULUS = 32'd65537;

	// command codes
	localparam logic [2:0] CMD_LOAD = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_MAC  = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_UNREDUCED  = 3'd1;
	localparam logic [2:0] ST_NOT_LOADED = 3'd2;
	localparam logic [2:0] ST_BAD_RECORD = 3'd3;
	localparam logic [2:0] ST_SEALED     = 3'd4;
	localparam logic [2:0] ST_FULL       = 3'd5;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] modulus;
		logic [MU_W-1:0]   mu;
	} tbl_wr_t;

endpackage

// ===== src/mva_table.sv =====
`timescale 1ns / 1ps
// Modulus and Barrett constant table: one write port, one registered read port.
// Depends on mva_pkg.
module mva_table (
	input  logic                          clk,
	input  mva_pkg::tbl_wr_t              wr,
	input  logic                          rd_en,
	input  logic [mva_pkg::IDX_W-1:0]     rd_addr,
	output logic [mva_pkg::DATA_W-1:0]    rd_modulus,
	output logic [mva_pkg::MU_W-1:0]      rd_mu
);
	import mva_pkg::*;

	logic [DATA_W+MU_W-1:0] mem [NUM_MODULI];
	logic [DATA_W+MU_W-1:0] rd_q;

	// write an appended entry
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= {wr.modulus, wr.mu};
		end
	end

	// registered read, hold while disabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_modulus = rd_q[DATA_W+MU_W-1:MU_W];
	assign rd_mu      = rd_q[MU_W-1:0];

endmodule

// ===== src/modular_vector_alu.sv =====
`timescale 1ns / 1ps
// Modular vector ALU: table load plus add, subtract, multiply and
// multiply-accumulate modulo a table entry, Barrett reduction in six stages.
// Each request passes through stages 1 to 6 and the output register to the result.
// Throughput: one arithmetic request per cycle unless a held result stalls the pipe; a load
// holds off further requests until its record check and table write finish.
// Reset clears the pipeline valids, fill count and seal; table contents stay
// undefined, as only entries below the fill count are ever used.
module modular_vector_alu (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [2:0]                  cmd,
	input  logic [7:0]                  mod_index,
	input  logic [31:0]                 left_operand,
	input  logic [31:0]                 right_operand,
	input  logic [31:0]                 accum_in,
	input  logic [31:0]                 new_modulus,
	input  logic [47:0]                 new_mu,
	input  logic                        last,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [31:0]                 result_value,
	output logic [2:0]                  status,
	output logic                        result_last
);
	import mva_pkg::*;

	localparam logic [80:0] TWO64 = 81'd1 << 64;

	logic adv, acc_req, load_busy;
	logic [CNT_W-1:0] entries_q;
	logic sealed_q;
	tbl_wr_t tbl_wr;
	logic [31:0] tq;
	logic [47:0] tmu;

	// stage 1
	logic v_s1, last_s1;
	logic [2:0] cmd_s1, st_s1;
	logic [31:0] l_s1, r_s1, acc_s1, nm_s1;
	logic [47:0] nmu_s1;
	// stage 2
	logic v_s2, last_s2;
	logic [2:0] cmd_s2, st_s2;
	logic [31:0] val_s2, q_s2, acc_s2, nm_s2;
	logic [47:0] mu_s2, pp1_s2, nmu_s2;
	logic [63:0] prod_s2;
	// stage 3
	logic v_s3, last_s3;
	logic [2:0] cmd_s3, st_s3;
	logic [31:0] val_s3, q_s3, acc_s3, nm_s3;
	logic [47:0] hh_s3, hl_s3, lh_s3, ll_s3, nmu_s3;
	logic [79:0] ldp_s3;
	logic [33:0] plo_s3;
	// stage 4
	logic v_s4, last_s4;
	logic [2:0] cmd_s4, st_s4;
	logic [31:0] val_s4, q_s4, acc_s4, qhat_s4;
	logic [33:0] plo_s4;
	// stage 5
	logic v_s5, last_s5;
	logic [2:0] cmd_s5, st_s5;
	logic [31:0] val_s5, q_s5, acc_s5;
	logic [33:0] plo_s5, qp_s5, q3_s5;
	// stage 6
	logic v_s6, last_s6;
	logic [2:0] cmd_s6, st_s6;
	logic [31:0] val_s6, q_s6, acc_s6, red_s6;
	// output
	logic v_out_q, last_out_q;
	logic [2:0] st_out_q;
	logic [31:0] val_out_q;

	// advance the whole pipe unless a finished result is held
	assign adv       = !v_out_q || !rsp_stall;
	assign load_busy = (v_s1 && cmd_s1 == CMD_LOAD) || (v_s2 && cmd_s2 == CMD_LOAD) ||
	                   (v_s3 && cmd_s3 == CMD_LOAD);
	assign req_stall = !adv || load_busy;
	assign acc_req   = req_valid && !req_stall;

	mva_table u_table (
		.clk        (clk),
		.wr         (tbl_wr),
		.rd_en      (adv),
		.rd_addr    (mod_index[IDX_W-1:0]),
		.rd_modulus (tq),
		.rd_mu      (tmu)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0; v_out_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_req; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5; v_out_q <= v_s6;
		end
	end

	// stage 0 to 1: early status from table state
	logic [2:0] st0;
	logic id_bad;
	always_comb begin
		id_bad = !sealed_q || ({24'd0, mod_index} >= 32'(entries_q));
		if (cmd == CMD_LOAD) begin
			if (sealed_q)                      st0 = ST_SEALED;
			else if (32'(entries_q) >= 32'(NUM_MODULI)) st0 = ST_FULL;
			else                               st0 = ST_OK;
		end else if (cmd > CMD_MAC) begin
			st0 = ST_BAD_RECORD;
		end else if (id_bad) begin
			st0 = ST_NOT_LOADED;
		end else begin
			st0 = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd; st_s1 <= st0; last_s1 <= last;
			l_s1 <= left_operand; r_s1 <= right_operand; acc_s1 <= accum_in;
			nm_s1 <= new_modulus; nmu_s1 <= new_mu;
		end
	end

	// stage 1 to 2: operand check, add/sub, first multiply
	logic unred;
	logic [32:0] sum1;
	logic [31:0] val1, ma, mb;
	always_comb begin
		unred = (l_s1 >= tq) || (r_s1 >= tq) || (cmd_s1 == CMD_MAC && acc_s1 >= tq);
		sum1  = {1'b0, l_s1} + {1'b0, r_s1};
		case (cmd_s1)
			CMD_ADD: val1 = (sum1 >= {1'b0, tq}) ? 32'(sum1 - {1'b0, tq}) : sum1[31:0];
			CMD_SUB: val1 = (l_s1 >= r_s1) ? l_s1 - r_s1 : l_s1 + tq - r_s1;
			default: val1 = 32'd0;
		endcase
		ma = (cmd_s1 == CMD_LOAD) ? nmu_s1[31:0] : l_s1;
		mb = (cmd_s1 == CMD_LOAD) ? nm_s1 : r_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2 <= cmd_s1; last_s2 <= last_s1;
			st_s2 <= (st_s1 == ST_OK && cmd_s1 != CMD_LOAD && unred) ? ST_UNREDUCED : st_s1;
			val_s2 <= val1; q_s2 <= tq; mu_s2 <= tmu; acc_s2 <= acc_s1; nm_s2 <= nm_s1;
			prod_s2 <= 64'(ma) * 64'(mb);
			pp1_s2 <= 48'(nmu_s1[47:32]) * 48'(nm_s1);
		end
	end

	// stage 2 to 3: Barrett partial products, load record product
	logic [23:0] a1, a0, m1, m0;
	assign a1 = prod_s2[63:40];
	assign a0 = prod_s2[39:16];
	assign m1 = mu_s2[47:24];
	assign m0 = mu_s2[23:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3 <= cmd_s2; st_s3 <= st_s2; last_s3 <= last_s2;
			val_s3 <= val_s2; q_s3 <= q_s2; acc_s3 <= acc_s2; nm_s3 <= nm_s2;
			hh_s3 <= 48'(a1) * 48'(m1);
			hl_s3 <= 48'(a1) * 48'(m0);
			lh_s3 <= 48'(a0) * 48'(m1);
			ll_s3 <= 48'(a0) * 48'(m0);
			ldp_s3 <= {16'd0, prod_s2} + {pp1_s2, 32'd0};
			plo_s3 <= prod_s2[33:0];
		end
	end

	// stage 3 to 4: quotient estimate, record check and table commit
	logic [95:0] wide;
	logic rec_ok, commit;
	logic [2:0] st3;
	always_comb begin
		wide = {hh_s3, 48'd0} + {24'd0, hl_s3, 24'd0} + {24'd0, lh_s3, 24'd0} + {48'd0, ll_s3};
		rec_ok = (nm_s3 >= MIN_MODULUS) && ({1'b0, ldp_s3} <= TWO64) &&
		         (({1'b0, ldp_s3} + {49'd0, nm_s3}) > TWO64);
		st3 = (cmd_s3 == CMD_LOAD && st_s3 == ST_OK && !rec_ok) ? ST_BAD_RECORD : st_s3;
		commit = adv && v_s3 && cmd_s3 == CMD_LOAD && st3 == ST_OK;
		tbl_wr.we      = commit;
		tbl_wr.addr    = entries_q[IDX_W-1:0];
		tbl_wr.modulus = nm_s3;
		tbl_wr.mu      = nmu_s3;
	end

	// carry the load constant alongside for the table write
	always_ff @(posedge clk) begin
		if (adv) begin
			nmu_s2 <= nmu_s1;
			nmu_s3 <= nmu_s2;
		end
	end

	// fill count and seal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			sealed_q  <= 1'b0;
		end else if (commit) begin
			entries_q <= entries_q + CNT_W'(1);
			if (last_s3) begin
				sealed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4 <= cmd_s3; st_s4 <= st3; last_s4 <= last_s3;
			val_s4 <= val_s3; q_s4 <= q_s3; acc_s4 <= acc_s3;
			qhat_s4 <= wide[79:48];
			plo_s4 <= plo_s3;
		end
	end

	// stage 4 to 5: quotient times modulus, low bits only
	logic [63:0] qp_full;
	assign qp_full = 64'(qhat_s4) * 64'(q_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s5 <= cmd_s4; st_s5 <= st_s4; last_s5 <= last_s4;
			val_s5 <= val_s4; q_s5 <= q_s4; acc_s5 <= acc_s4;
			plo_s5 <= plo_s4;
			qp_s5 <= qp_full[33:0];
			q3_s5 <= {2'd0, q_s4} + {1'd0, q_s4, 1'b0};
		end
	end

	// stage 5 to 6: remainder below four moduli, correct once
	logic [33:0] rr, q1x, q2x, sub5;
	always_comb begin
		rr  = plo_s5 - qp_s5;
		q1x = {2'd0, q_s5};
		q2x = {1'd0, q_s5, 1'b0};
		if (rr >= q3_s5)    sub5 = q3_s5;
		else if (rr >= q2x) sub5 = q2x;
		else if (rr >= q1x) sub5 = q1x;
		else                sub5 = 34'd0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s6 <= cmd_s5; st_s6 <= st_s5; last_s6 <= last_s5;
			val_s6 <= val_s5; q_s6 <= q_s5; acc_s6 <= acc_s5;
			red_s6 <= 32'(rr - sub5);
		end
	end

	// stage 6 to output: accumulate and pick the result
	logic [32:0] macs;
	logic [31:0] val6;
	always_comb begin
		macs = {1'b0, acc_s6} + {1'b0, red_s6};
		case (cmd_s6)
			CMD_ADD, CMD_SUB: val6 = val_s6;
			CMD_MUL:          val6 = red_s6;
			CMD_MAC:          val6 = (macs >= {1'b0, q_s6}) ? 32'(macs - {1'b0, q_s6})
			                                                : macs[31:0];
			default:          val6 = 32'd0;
		endcase
		if (st_s6 != ST_OK) begin
			val6 = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_out_q  <= val6;
			st_out_q   <= st_s6;
			last_out_q <= last_s6;
		end
	end

	assign rsp_valid    = v_out_q;
	assign result_value = val_out_q;
	assign status       = st_out_q;
	assign result_last  = last_out_q;

endmodule

// ===== sim/tb_modular_vector_alu.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for modular_vector_alu: table loads, sealing and
// modular add/sub/mul/mac checked against a local predictor.
// Depends on mva_pkg and the modular_vector_alu RTL only.
module tb_modular_vector_alu;
	import mva_pkg::*;

	localparam int TABLE_FILL = 200;  // seal below capacity so unloaded ids stay reachable

	typedef struct {
		logic [31:0] value;
		logic [2:0]  status;
		logic        last;
	} alu_result_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  cmd;
	logic [7:0]  mod_index;
	logic [31:0] left_operand;
	logic [31:0] right_operand;
	logic [31:0] accum_in;
	logic [31:0] new_modulus;
	logic [47:0] new_mu;
	logic        last;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [31:0] result_value;
	logic [2:0]  status;
	logic        result_last;

	modular_vector_alu dut (.*);

	// predictor state
	logic [31:0] moduli[NUM_MODULI];
	int          fill_count;
	bit          sealed;
	alu_result_t pending_results[$];
	int          error_count;

	// sender and receiver pacing
	int burst_left;
	bit sender_gaps;
	int stall_mode;
	int hold_count;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [47:0] floor_mu(input logic [31:0] m);
		logic [64:0] quotient;
		quotient = {1'b1, 64'd0} / {33'd0, m};
		return quotient[47:0];
	endfunction

	// work out the result of one request and update the table state
	function automatic alu_result_t predict_result(input logic [2:0] c, input logic [7:0] id,
			input logic [31:0] l, input logic [31:0] r, input logic [31:0] acc,
			input logic [31:0] nm, input logic [47:0] nmu, input logic lst);
		alu_result_t res;
		longint unsigned q, s, p;
		res.value  = '0;
		res.status = ST_OK;
		res.last   = lst;
		if (c == CMD_LOAD) begin
			if (sealed)
				res.status = ST_SEALED;
			else if (fill_count >= NUM_MODULI)
				res.status = ST_FULL;
			else if (nm < MIN_MODULUS || nmu != floor_mu(nm))
				res.status = ST_BAD_RECORD;
			else begin
				moduli[fill_count] = nm;
				fill_count++;
				if (lst)
					sealed = 1'b1;
			end
		end else if (c > CMD_MAC) begin
			res.status = ST_BAD_RECORD;
		end else if (!sealed || id >= fill_count) begin
			res.status = ST_NOT_LOADED;
		end else begin
			q = 64'(moduli[id]);
			if (l >= q || r >= q || (c == CMD_MAC && acc >= q))
				res.status = ST_UNREDUCED;
			else begin
				p = (64'(l) * 64'(r)) % q;
				case (c)
					CMD_ADD: begin
						s = 64'(l) + 64'(r);
						res.value = 32'((s >= q) ? s - q : s);
					end
					CMD_SUB: res.value = (l >= r) ? l - r : 32'(64'(l) + q - 64'(r));
					CMD_MUL: res.value = 32'(p);
					default: begin
						s = 64'(acc) + p;
						res.value = 32'((s >= q) ? s - q : s);
					end
				endcase
			end
		end
		return res;
	endfunction

	// offer one request, wait for accept, record its expected result
	task automatic send_request(input logic [2:0] c, input logic [7:0] id,
			input logic [31:0] l, input logic [31:0] r, input logic [31:0] acc,
			input logic [31:0] nm, input logic [47:0] nmu, input logic lst);
		alu_result_t expected;
		if (sender_gaps && burst_left == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		cmd           = c;
		mod_index     = id;
		left_operand  = l;
		right_operand = r;
		accum_in      = acc;
		new_modulus   = nm;
		new_mu        = nmu;
		last          = lst;
		req_valid     = 1'b1;
		do @(posedge clk); while (req_stall);
		expected = predict_result(c, id, l, r, acc, nm, nmu, lst);
		pending_results = {pending_results, expected};
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	function automatic logic [31:0] random_modulus();
		case ($urandom_range(0, 5))
			0:       return MIN_MODULUS + $urandom_range(0, 3);
			1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2:       return 32'h0001_0001 + $urandom_range(0, 32'h00FF_FFFF);
			default: return $urandom_range(MIN_MODULUS, 32'hFFFF_FFFF);
		endcase
	endfunction

	function automatic logic [31:0] reduced_operand(input logic [31:0] q);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return q - 1;
			default: return $urandom_range(0, q - 1);
		endcase
	endfunction

	// send a malformed load record
	task automatic send_bad_load(input logic lst);
		logic [31:0] m;
		m = random_modulus();
		case ($urandom_range(0, 2))
			0: send_request(CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom,
					32'd65536, floor_mu(32'd65536), lst);
			1: send_request(CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom,
					$urandom_range(0, 65536), 48'({$urandom, $urandom}), lst);
			default: send_request(CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom,
					m, floor_mu(m) ^ (48'd1 << $urandom_range(0, 47)), lst);
		endcase
	endtask

	// one arithmetic request; mostly reduced operands on loaded ids
	task automatic send_arith(input int unreduced_pct);
		logic [2:0]  c;
		logic [7:0]  id;
		logic [31:0] q, l, r, acc;
		c   = 3'($urandom_range(CMD_ADD, CMD_MAC));
		id  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(TABLE_FILL, 255))
			: 8'($urandom_range(0, TABLE_FILL - 1));
		q   = (id < fill_count) ? moduli[id] : 32'hFFFF_FFFF;
		l   = reduced_operand(q);
		r   = reduced_operand(q);
		acc = reduced_operand(q);
		if ($urandom_range(0, 99) < unreduced_pct)
			case ($urandom_range(0, 2))
				0: l   = $urandom_range(q, 32'hFFFF_FFFF);
				1: r   = $urandom_range(q, 32'hFFFF_FFFF);
				default: acc = $urandom_range(q, 32'hFFFF_FFFF);
			endcase
		send_request(c, id, l, r, acc, $urandom, 48'({$urandom, $urandom}), 1'($urandom));
	endtask

	// receiver stall pattern, with a counted long hold on request
	initial begin
		int hold_cycles;
		int phase;
		int holds_seen;
		rsp_stall   = 1'b0;
		phase       = 0;
		hold_cycles = 0;
		holds_seen  = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_count != holds_seen) begin
				holds_seen  = hold_count;
				hold_cycles = 300;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_stall = 1'b1;
			end else
				case (stall_mode)
					0:       rsp_stall = 1'b0;
					1:       rsp_stall = ($urandom_range(0, 99) < 35);
					default: rsp_stall = (phase % 7) < 3;
				endcase
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		alu_result_t exp_res;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: value=%h status=%0d", result_value, status);
				error_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (result_value !== exp_res.value) begin
					$error("result_value expected %h actual %h", exp_res.value, result_value);
					error_count++;
				end
				if (status !== exp_res.status) begin
					$error("status expected %0d actual %0d", exp_res.status, status);
					error_count++;
				end
				if (result_last !== exp_res.last) begin
					$error("result_last expected %0b actual %0b", exp_res.last, result_last);
					error_count++;
				end
			end
		end
	end

	// arithmetic, unknown commands and a bad load before the table is sealed
	task automatic test_before_seal();
		send_request(CMD_ADD, 8'd0, '0, '0, '0, '0, '0, 1'b0);
		send_request(CMD_MAC, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
		send_request(3'd5, 8'($urandom), $urandom, $urandom, $urandom, $urandom, '0, 1'b0);
		send_request(3'd6, 8'($urandom), $urandom, $urandom, $urandom, $urandom, '0, 1'b1);
		send_request(3'd7, 8'hFF, '1, '1, '1, '1, '1, 1'b1);
		send_bad_load(1'b1);
	endtask

	// fill the table, with bad records mixed in, and seal on the last entry
	task automatic test_table_load();
		logic [31:0] m;
		for (int i = 0; i < TABLE_FILL; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_bad_load(1'($urandom));
			if (i == 0)
				m = MIN_MODULUS;
			else if (i == 1)
				m = 32'hFFFF_FFFF;
			else
				m = random_modulus();
			send_request(CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom, m,
				floor_mu(m), i == TABLE_FILL - 1);
		end
	endtask

	// extremes after the seal: loads rejected, ids, operand bounds
	task automatic test_directed_arith();
		logic [31:0] m;
		m = random_modulus();
		send_request(CMD_LOAD, '0, '0, '0, '0, m, floor_mu(m), 1'b0);
		send_bad_load(1'b1);
		send_request(CMD_ADD, 8'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, '0, '0, '0, 1'b0);
		send_request(CMD_SUB, 8'd1, '0, 32'hFFFF_FFFE, '0, '0, '0, 1'b1);
		send_request(CMD_MUL, 8'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, '1, '1, '1, 1'b0);
		send_request(CMD_MAC, 8'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE,
			'0, '0, 1'b1);
		send_request(CMD_MUL, 8'd0, 32'd65536, 32'd65536, '0, '0, '0, 1'b0);
		send_request(CMD_ADD, 8'd0, 32'd65537, 32'd0, '0, '0, '0, 1'b0);
		send_request(CMD_MAC, 8'd0, 32'd1, 32'd1, 32'd65537, '0, '0, 1'b0);
		send_request(CMD_SUB, 8'd0, '0, '0, '0, '0, '0, 1'b0);
		send_request(CMD_ADD, 8'(TABLE_FILL - 1), '0, '0, '0, '0, '0, 1'b0);
		send_request(CMD_ADD, 8'(TABLE_FILL), '0, '0, '0, '0, '0, 1'b0);
		send_request(CMD_MUL, 8'd255, '0, '0, '0, '0, '0, 1'b1);
		send_request(3'd7, 8'd0, '0, '0, '0, '0, '0, 1'b0);
	endtask

	// random stream, mostly arithmetic with unknown commands and bad loads, under several pacing modes
	task automatic test_random_stream();
		for (int i = 0; i < 600; i++) begin
			if (i % 150 == 0) begin
				stall_mode  = (i / 150) % 3;
				sender_gaps = (i / 150) != 2;
			end
			if ($urandom_range(0, 39) == 0)
				send_request(3'($urandom_range(5, 7)), 8'($urandom), $urandom, $urandom,
					$urandom, $urandom, 48'({$urandom, $urandom}), 1'($urandom));
			else if ($urandom_range(0, 39) == 0)
				send_bad_load(1'($urandom));
			else
				send_arith(10);
		end
	endtask

	// long receiver hold while requests keep coming, so the pipe backs up
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		stall_mode  = 0;
		hold_count++;
		repeat (60) send_arith(5);
		sender_gaps = 1'b1;
	endtask

	initial begin
		#2_000_000;
		$display("tb_modular_vector_alu failed");
		$finish;
	end

	initial begin
		int wait_cycles;
		clk           = 1'b0;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		cmd           = CMD_LOAD;
		mod_index     = '0;
		left_operand  = '0;
		right_operand = '0;
		accum_in      = '0;
		new_modulus   = '0;
		new_mu        = '0;
		last          = 1'b0;
		fill_count    = 0;
		sealed        = 1'b0;
		burst_left    = 0;
		sender_gaps   = 1'b1;
		stall_mode    = 1;
		hold_count    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_before_seal();
		test_table_load();
		test_directed_arith();
		test_backpressure();
		test_random_stream();

		// drain outstanding results, then allow the pipeline to settle
		stall_mode  = 1;
		wait_cycles = 0;
		while (pending_results.size() != 0 && wait_cycles < 100_000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_modular_vector_alu passed");
		else
			$display("tb_modular_vector_alu failed");
		$finish;
	end

endmodule
